### design/order_statistic_count_tree_defines.svh
// Assertion macros for the order statistic count tree checker.
// Every macro clocks on i_clk and is disabled while i_rst_n is low.
`ifndef ORDER_STATISTIC_COUNT_TREE_DEFINES_SVH
`define ORDER_STATISTIC_COUNT_TREE_DEFINES_SVH

// Property that holds at every clock edge.
`define OST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define OST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ost_pkg.sv
// Shared types and constants for the order statistic count tree.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package ost_pkg;

    localparam int ACT_W   = 2;
    localparam int RANK_W  = 26;
    localparam int POS_W   = 11;
    localparam int AMT_W   = 16;
    localparam int TOTAL_W = 26;

    localparam int DEF_MAX_POSITIONS = 1024;
    localparam int DEF_COUNT_BITS    = 16;
    localparam int RESET_USED_SIZE   = 1024;

    // Action codes; any other code acts as a plain select.
    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic [RANK_W-1:0]        rank;
        logic [POS_W-1:0]         position;
        logic signed [AMT_W-1:0]  amount;
    } t_in;

    typedef struct packed {
        logic [POS_W-1:0]   found_position;
        logic               in_range;
        logic [TOTAL_W-1:0] total_count;
    } t_out;

endpackage

### design/ost_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ost_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/order_statistic_count_tree.sv
// Order statistic count tree: top level with the control sequencer.
// Depends on ost_pkg and two ost_ram instances (leaf counts, tree sums).
`timescale 1ns / 1ps
//
//  channel   direction  handshake                     payload
//  cfg       in         i_cfg_valid / o_cfg_ready     i_cfg_data (used_size)
//  in        in         i_in_valid  / o_in_ready      i_in_item  (ost_pkg::t_in)
//  out       out        o_out_valid / i_out_ready     o_out_item (ost_pkg::t_out)
//
//  Flow: one item at a time. A select walks PW = clog2(MAX_POSITIONS+1) tree
//  levels (read a node sum, then compare; a node beyond the used size is not
//  compared) on the single read port of the sum RAM. An add skips the walk and
//  does a leaf read-modify-write and an ascent; a remove does the walk and both.
//  Reset: the leaf RAM is filled with ones, then the sums are built; no item or
//  write is taken meanwhile. Each used_size write rebuilds the sums the same way.
//  Stalls: a finished result waits in the output register; the next item is
//  taken meanwhile and holds in its last state only if the register is still full.

module order_statistic_count_tree #(
    parameter int MAX_POSITIONS = ost_pkg::DEF_MAX_POSITIONS,
    parameter int COUNT_BITS    = ost_pkg::DEF_COUNT_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [ost_pkg::POS_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  ost_pkg::t_in              i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output ost_pkg::t_out             o_out_item
);

    import ost_pkg::*;

    // Position width (holds MAX_POSITIONS), index width with one guard bit for
    // the ascent, RAM address width and tree sum width.
    localparam int PW = $clog2(MAX_POSITIONS + 1);
    localparam int IW = PW + 1;
    localparam int AW = $clog2(MAX_POSITIONS);
    localparam int SW = COUNT_BITS + $clog2(MAX_POSITIONS);
    localparam int XW = (PW > POS_W) ? PW : POS_W;
    localparam int CW = (SW > RANK_W) ? SW : RANK_W;
    localparam int DW = COUNT_BITS + 1;
    localparam int NW = ((COUNT_BITS > AMT_W) ? COUNT_BITS : AMT_W) + 2;
    localparam int LW = $clog2(PW + 1);

    localparam logic [PW-1:0] TOP_STEP = {1'b1, {(PW - 1){1'b0}}};
    localparam logic [PW-1:0] RESET_USED = (RESET_USED_SIZE > MAX_POSITIONS) ?
        PW'(MAX_POSITIONS) : PW'(RESET_USED_SIZE);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic signed [NW-1:0]  NV_MAX = NW'($signed({1'b0, COUNT_MAX}));

    // Sequencer states.
    localparam logic [3:0] ST_FILL  = 4'd0;  // write ones into every leaf
    localparam logic [3:0] ST_BUILD = 4'd1;  // stream leaves, write tree sums
    localparam logic [3:0] ST_IDLE  = 4'd2;
    localparam logic [3:0] ST_WALK  = 4'd3;  // issue the node read of one level
    localparam logic [3:0] ST_CMP   = 4'd4;  // compare node sum against rank
    localparam logic [3:0] ST_LEAF  = 4'd5;  // read the target leaf
    localparam logic [3:0] ST_UPD   = 4'd6;  // write the new leaf count
    localparam logic [3:0] ST_ADJ   = 4'd7;  // ascend, adding the delta to sums
    localparam logic [3:0] ST_DONE  = 4'd8;  // hand the result to the output

    function automatic logic [LW-1:0] f_lsb(input logic [IW-1:0] x);
        logic [LW-1:0] v;
        v = '0;
        for (int b = IW - 1; b >= 0; b--) begin
            if (x[b]) begin
                v = LW'(b);
            end
        end
        return v;
    endfunction

    logic [3:0]              r_state;
    logic [PW-1:0]           r_used;
    logic [SW-1:0]           r_total;
    logic [IW-1:0]           r_idx;
    logic                    r_rd_v;
    logic [IW-1:0]           r_rd_idx;
    logic [SW-1:0]           r_prefix;
    logic [SW-1:0]           r_last [PW+1];
    logic [PW-1:0]           r_pos;
    logic [PW-1:0]           r_step;
    logic [RANK_W-1:0]       r_k;
    logic [ACT_W-1:0]        r_action;
    logic [PW-1:0]           r_found;
    logic signed [AMT_W-1:0] r_amount;
    logic signed [DW-1:0]    r_delta;
    logic                    r_ok;
    logic                    r_out_valid;
    t_out                    r_out;

    // RAM ports
    logic                  lf_we, lf_re, sm_we, sm_re;
    logic [AW-1:0]         lf_waddr, lf_raddr, sm_waddr, sm_raddr;
    logic [COUNT_BITS-1:0] lf_wdata, lf_rdata;
    logic [SW-1:0]         sm_wdata, sm_rdata;

    // Datapath
    logic [PW-1:0]          w_nxt;
    logic                   w_nxt_ok;
    logic                   w_take;
    logic [PW-1:0]          w_pos_new;
    logic                   w_step_last;
    logic [IW-1:0]          w_found_inc;
    logic [PW-1:0]          w_found;
    logic [LW-1:0]          w_bld_lsb;
    logic [SW-1:0]          w_prefix_new;
    logic [SW-1:0]          w_bld_sum;
    logic                   w_bld_issue;
    logic                   w_adj_issue;
    logic [IW-1:0]          w_lowbit;
    logic signed [NW-1:0]   w_sum_nv;
    logic [COUNT_BITS-1:0]  w_new;
    logic signed [DW-1:0]   w_delta;
    logic [PW-1:0]          w_cfg_used;
    logic [XW-1:0]          w_pos_x;
    logic                   w_cfg_acc;
    logic                   w_in_acc;

    ost_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_POSITIONS)) u_leaf_ram (
        .i_clk   (i_clk),
        .i_we    (lf_we),
        .i_waddr (lf_waddr),
        .i_wdata (lf_wdata),
        .i_re    (lf_re),
        .i_raddr (lf_raddr),
        .o_rdata (lf_rdata)
    );

    ost_ram #(.WIDTH(SW), .DEPTH(MAX_POSITIONS)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sm_we),
        .i_waddr (sm_waddr),
        .i_wdata (sm_wdata),
        .i_re    (sm_re),
        .i_raddr (sm_raddr),
        .o_rdata (sm_rdata)
    );

    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_in_ready  = (r_state == ST_IDLE) && !i_cfg_valid;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Clamp the written size to 1..MAX_POSITIONS.
    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_used = PW'(1);
        end else if (XW'(i_cfg_data) > XW'(MAX_POSITIONS)) begin
            w_cfg_used = PW'(MAX_POSITIONS);
        end else begin
            w_cfg_used = PW'(i_cfg_data);
        end
    end

    assign w_pos_x = XW'(i_in_item.position);

    // Rank walk: WALK/CMP per level, WALK alone past the used size; step halves.
    assign w_nxt       = r_pos + r_step;
    assign w_nxt_ok    = (w_nxt <= r_used);
    assign w_take      = (CW'(sm_rdata) < CW'(r_k));
    assign w_pos_new   = ((r_state == ST_CMP) && w_take) ? w_nxt : r_pos;
    assign w_step_last = (r_step == PW'(1));
    assign w_found_inc = IW'(w_pos_new) + IW'(1);
    assign w_found     = (w_found_inc > IW'(r_used)) ? r_used : PW'(w_found_inc);

    // Sum build: node i covers (i & (i-1)) + 1 .. i, so its sum is the running
    // prefix minus the prefix saved at the last index with a larger low bit.
    assign w_bld_issue  = (r_idx <= IW'(r_used));
    assign w_bld_lsb    = f_lsb(r_rd_idx);
    assign w_prefix_new = r_prefix + SW'(lf_rdata);
    assign w_bld_sum    = w_prefix_new - r_last[w_bld_lsb + LW'(1)];

    // Ascent: visit i, i + lowbit(i), ... while within the used range.
    assign w_adj_issue = (r_idx != '0) && (r_idx <= IW'(r_used));
    assign w_lowbit    = r_idx & (~r_idx + IW'(1));

    // Leaf update: saturating add, or decrement that stops at zero.
    assign w_sum_nv = NW'($signed({1'b0, lf_rdata})) + NW'(r_amount);
    always_comb begin
        if (r_action == ACT_ADD) begin
            if (w_sum_nv < 0) begin
                w_new = '0;
            end else if (w_sum_nv > NV_MAX) begin
                w_new = COUNT_MAX;
            end else begin
                w_new = w_sum_nv[COUNT_BITS-1:0];
            end
        end else begin
            w_new = (lf_rdata != '0) ? (lf_rdata - COUNT_BITS'(1)) : lf_rdata;
        end
    end
    assign w_delta = $signed({1'b0, w_new}) - $signed({1'b0, lf_rdata});

    // RAM port steering per state.
    always_comb begin
        lf_we    = 1'b0;
        lf_waddr = '0;
        lf_wdata = '0;
        lf_re    = 1'b0;
        lf_raddr = '0;
        sm_we    = 1'b0;
        sm_waddr = '0;
        sm_wdata = '0;
        sm_re    = 1'b0;
        sm_raddr = '0;
        unique case (r_state)
            ST_FILL: begin
                lf_we    = 1'b1;
                lf_waddr = AW'(r_idx);
                lf_wdata = COUNT_BITS'(1);
            end
            ST_BUILD: begin
                lf_re    = w_bld_issue;
                lf_raddr = AW'(r_idx - IW'(1));
                sm_we    = r_rd_v;
                sm_waddr = AW'(r_rd_idx - IW'(1));
                sm_wdata = w_bld_sum;
            end
            ST_WALK: begin
                sm_re    = w_nxt_ok;
                sm_raddr = AW'(w_nxt - PW'(1));
            end
            ST_LEAF: begin
                lf_re    = 1'b1;
                lf_raddr = AW'(r_found - PW'(1));
            end
            ST_UPD: begin
                lf_we    = 1'b1;
                lf_waddr = AW'(r_found - PW'(1));
                lf_wdata = w_new;
            end
            ST_ADJ: begin
                sm_re    = w_adj_issue;
                sm_raddr = AW'(r_idx - IW'(1));
                sm_we    = r_rd_v;
                sm_waddr = AW'(r_rd_idx - IW'(1));
                sm_wdata = sm_rdata + SW'(r_delta);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_idx       <= '0;
            r_used      <= RESET_USED;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the result once the consumer takes it; a finished item
            // reloads the register in ST_DONE instead.
            if (r_out_valid && i_out_ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_FILL: begin
                    if (r_idx == IW'(MAX_POSITIONS - 1)) begin
                        r_state  <= ST_BUILD;
                        r_idx    <= IW'(1);
                        r_rd_v   <= 1'b0;
                        r_prefix <= '0;
                        r_last   <= '{default: '0};
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end

                ST_BUILD: begin
                    // Read stage: one leaf per cycle.
                    r_rd_v   <= w_bld_issue;
                    r_rd_idx <= r_idx;
                    if (w_bld_issue) begin
                        r_idx <= r_idx + IW'(1);
                    end
                    // Write stage: advance the prefix, save it at the levels
                    // this index closes.
                    if (r_rd_v) begin
                        r_prefix <= w_prefix_new;
                        for (int k = 0; k <= PW; k++) begin
                            if (LW'(k) <= w_bld_lsb) begin
                                r_last[k] <= w_prefix_new;
                            end
                        end
                        if (r_rd_idx == IW'(r_used)) begin
                            r_total <= w_prefix_new;
                            r_state <= ST_IDLE;
                        end
                    end
                end

                ST_IDLE: begin
                    if (w_cfg_acc) begin
                        r_used   <= w_cfg_used;
                        r_state  <= ST_BUILD;
                        r_idx    <= IW'(1);
                        r_rd_v   <= 1'b0;
                        r_prefix <= '0;
                        r_last   <= '{default: '0};
                    end else if (w_in_acc) begin
                        r_action <= i_in_item.action;
                        r_amount <= i_in_item.amount;
                        if (i_in_item.action == ACT_ADD) begin
                            if ((w_pos_x != '0) && (w_pos_x <= XW'(r_used))) begin
                                r_found <= PW'(i_in_item.position);
                                r_ok    <= 1'b1;
                                r_state <= ST_LEAF;
                            end else begin
                                // Out of range: echo the clamped position only.
                                r_found <= (w_pos_x == '0) ? PW'(1) : r_used;
                                r_ok    <= 1'b0;
                                r_state <= ST_DONE;
                            end
                        end else begin
                            r_ok    <= (i_in_item.rank != '0) &&
                                       (CW'(i_in_item.rank) <= CW'(r_total));
                            r_k     <= i_in_item.rank;
                            r_pos   <= '0;
                            r_step  <= TOP_STEP;
                            r_state <= ST_WALK;
                        end
                    end
                end

                ST_WALK: begin
                    if (w_nxt_ok) begin
                        r_state <= ST_CMP;
                    end else if (w_step_last) begin
                        r_found <= w_found;
                        r_state <= (r_action == ACT_REMOVE) ? ST_LEAF : ST_DONE;
                    end else begin
                        r_step <= r_step >> 1;
                    end
                end

                ST_CMP: begin
                    r_pos <= w_pos_new;
                    if (w_take) begin
                        r_k <= r_k - RANK_W'(sm_rdata);
                    end
                    if (w_step_last) begin
                        r_found <= w_found;
                        r_state <= (r_action == ACT_REMOVE) ? ST_LEAF : ST_DONE;
                    end else begin
                        r_step  <= r_step >> 1;
                        r_state <= ST_WALK;
                    end
                end

                ST_LEAF: begin
                    r_state <= ST_UPD;
                end

                ST_UPD: begin
                    r_delta <= w_delta;
                    r_idx   <= IW'(r_found);
                    r_rd_v  <= 1'b0;
                    r_state <= ST_ADJ;
                end

                ST_ADJ: begin
                    // Reads run one node ahead of the write-back; the ascent
                    // never revisits a node, so no forwarding is needed.
                    r_rd_v   <= w_adj_issue;
                    r_rd_idx <= r_idx;
                    if (w_adj_issue) begin
                        r_idx <= r_idx + w_lowbit;
                    end else if (!r_rd_v) begin
                        r_total <= r_total + SW'(r_delta);
                        r_state <= ST_DONE;
                    end
                end

                ST_DONE: begin
                    // Hold here while the previous result still waits.
                    if (!r_out_valid || i_out_ready) begin
                        r_out.found_position <= POS_W'(r_found);
                        r_out.in_range       <= r_ok;
                        r_out.total_count    <= TOTAL_W'(r_total);
                        r_out_valid          <= 1'b1;
                        r_state              <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### design/ost_checker.sv
// Port-level checker for the order statistic count tree, bound to the top level.
// Depends on ost_pkg and order_statistic_count_tree_defines.svh.
`timescale 1ns / 1ps
`include "order_statistic_count_tree_defines.svh"

module ost_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_cfg_valid,
    input logic          o_cfg_ready,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input ost_pkg::t_out o_out_item
);

    // A stalled result holds.
    `OST_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item), "result changed while stalled")

    // Positions count from one.
    `OST_ASSERT(a_found_nonzero, o_out_valid |-> (o_out_item.found_position != '0), "found position is zero")

    // An accepted item keeps both channels closed on the next cycle.
    `OST_ASSERT_NEXT(a_busy_after_item, i_in_valid && o_in_ready, !o_in_ready && !o_cfg_ready, "ready right after an item")

    // A size write starts a rebuild that closes both channels.
    `OST_ASSERT_NEXT(a_busy_after_cfg, i_cfg_valid && o_cfg_ready, !o_in_ready && !o_cfg_ready, "ready right after a size write")

endmodule

bind order_statistic_count_tree ost_checker u_ost_checker (.*);

### bench/count_tree_checker.sv
// Result checker for the order statistic count tree: watches the config, item
// and result channels, predicts each result and compares it field by field.
// Depends on ost_pkg only.
`timescale 1ns / 1ps

module count_tree_checker #(
    parameter int MAX_POSITIONS = ost_pkg::DEF_MAX_POSITIONS,
    parameter int COUNT_BITS    = ost_pkg::DEF_COUNT_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [ost_pkg::POS_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  ost_pkg::t_in              i_in_item,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  ost_pkg::t_out             i_out_item,
    output int                        o_mismatches,
    output int                        o_results_seen,
    output int                        o_total
);

    localparam longint COUNT_MAX = (longint'(1) << COUNT_BITS) - 1;

    longint        counts [1:MAX_POSITIONS];
    int            span;
    longint        total;
    ost_pkg::t_out answers_q [$];
    int            mismatches;
    int            results_seen;

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        if (mismatches < 100)
            $display("%0t ns  %s: got %0d, expected %0d", $time, what, got, exp);
        mismatches++;
    endtask

    // Clamp the size and re-sum the counts in use; counts beyond it are kept.
    task automatic resize(input logic [ost_pkg::POS_W-1:0] v);
        int p;
        if (v == 0)
            span = 1;
        else if (v > MAX_POSITIONS)
            span = MAX_POSITIONS;
        else
            span = v;
        total = 0;
        for (p = 1; p <= span; p++)
            total += counts[p];
    endtask

    // Smallest position whose prefix count reaches k, else the last one in use.
    function automatic int walk_rank(input longint k);
        longint run;
        int     p;
        run = 0;
        for (p = 1; p <= span; p++) begin
            run += counts[p];
            if (run >= k)
                return p;
        end
        return span;
    endfunction

    task automatic derive_answer(input ost_pkg::t_in it, output ost_pkg::t_out ans);
        int     pos;
        int     amt;
        longint nv;
        ans = '0;
        if (it.action == ost_pkg::ACT_ADD) begin
            pos = it.position;
            amt = {{(32-ost_pkg::AMT_W){it.amount[ost_pkg::AMT_W-1]}}, it.amount};
            if (pos >= 1 && pos <= span) begin
                nv = counts[pos] + amt;
                if (nv < 0)
                    nv = 0;
                else if (nv > COUNT_MAX)
                    nv = COUNT_MAX;
                total = total - counts[pos] + nv;
                counts[pos] = nv;
                ans.found_position = (ost_pkg::POS_W)'(pos);
                ans.in_range = 1'b1;
            end else begin
                ans.found_position = (ost_pkg::POS_W)'((pos < 1) ? 1 : span);
                ans.in_range = 1'b0;
            end
        end else begin
            ans.in_range = (it.rank >= 1 && it.rank <= total);
            pos = walk_rank(it.rank);
            ans.found_position = (ost_pkg::POS_W)'(pos);
            // remove takes one off the found count, even for an out-of-range rank
            if (it.action == ost_pkg::ACT_REMOVE && counts[pos] > 0) begin
                counts[pos]--;
                total--;
            end
        end
        ans.total_count = (ost_pkg::TOTAL_W)'(total);
    endtask

    always @(posedge i_clk) begin
        ost_pkg::t_out want;
        int p;
        if (!i_rst_n) begin
            for (p = 1; p <= MAX_POSITIONS; p++)
                counts[p] = 1;
            resize((ost_pkg::POS_W)'(ost_pkg::RESET_USED_SIZE));
            answers_q.delete();
            mismatches = 0;
            results_seen = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                resize(i_cfg_data);
            if (i_out_valid && i_out_ready) begin
                results_seen++;
                if (answers_q.size() == 0) begin
                    report_mismatch("result with no item waiting",
                                    i_out_item.found_position, 0);
                end else begin
                    want = answers_q.pop_front();
                    if (i_out_item.found_position !== want.found_position)
                        report_mismatch("found_position", i_out_item.found_position,
                                        want.found_position);
                    if (i_out_item.in_range !== want.in_range)
                        report_mismatch("in_range", i_out_item.in_range, want.in_range);
                    if (i_out_item.total_count !== want.total_count)
                        report_mismatch("total_count", i_out_item.total_count,
                                        want.total_count);
                end
            end
            if (i_in_valid && i_in_ready) begin
                derive_answer(i_in_item, want);
                answers_q.insert(answers_q.size(), want);
            end
        end
        o_mismatches   <= mismatches;
        o_results_seen <= results_seen;
        o_total        <= int'(total);
    end

endmodule

### bench/tb.sv
// Top of the order statistic count tree bench: clock, reset, stimulus and verdict.
// Depends on ost_pkg, the block order_statistic_count_tree and count_tree_checker.
`timescale 1ns / 1ps

module tb;

    import ost_pkg::*;

    // Plain select and the unused code, which must also behave as a select.
    localparam logic [ACT_W-1:0] ACT_SELECT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SPARE  = 2'd3;

    localparam int  NUM_PHASES      = 12;
    localparam int  ITEMS_PER_PHASE = 160;
    localparam int  DRAIN_CYCLES    = 60;
    localparam logic [RANK_W-1:0] RANK_TOP = '1;
    localparam logic [POS_W-1:0]  POS_TOP  = '1;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [POS_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in              i_in_item;
    logic             o_out_valid;
    logic             i_out_ready;
    t_out             o_out_item;

    int mismatches;
    int results_seen;
    int model_total;
    int items_sent;
    int span_now;
    int burst_left;
    int phase_spans [NUM_PHASES];

    order_statistic_count_tree DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    count_tree_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_in_item      (i_in_item),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_out_item     (o_out_item),
        .o_mismatches   (mismatches),
        .o_results_seen (results_seen),
        .o_total        (model_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Generous watchdog: covers the fill and build after reset, every rebuild
    // and every item meeting the longest gaps and stalls on both sides.
    initial begin
        #15_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Sender gap: mostly none or short, a few long, and now and then a burst
    // of back-to-back items so the block also sees a full-rate stream.
    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            burst_left = $urandom_range(30, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // Result side: ready runs of random length, long runs now and then, broken
    // by stalls that are mostly short.
    initial begin
        int run_len;
        int stall;
        int r;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            r = $urandom_range(0, 99);
            run_len = (r < 10) ? $urandom_range(50, 200) : $urandom_range(1, 6);
            i_out_ready <= 1'b1;
            repeat (run_len) @(posedge i_clk);
            r = $urandom_range(0, 99);
            if (r < 60)
                stall = 0;
            else if (r < 88)
                stall = $urandom_range(1, 3);
            else if (r < 97)
                stall = $urandom_range(4, 10);
            else
                stall = $urandom_range(15, 40);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // Offer one item and hold it until taken. Valid stays high on return, so a
    // following item with no gap is offered straight away.
    task automatic send_item(input t_in it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // Drop valid and hold until every item sent has come back as a result.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_seen < items_sent);
    endtask

    // Change the size only with the block idle; it then rebuilds its sums and
    // holds off items on its own until that is done.
    task automatic write_span(input logic [POS_W-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (v == 0)
            span_now = 1;
        else if (v > DEF_MAX_POSITIONS)
            span_now = DEF_MAX_POSITIONS;
        else
            span_now = v;
    endtask

    function automatic t_in mk_item(input logic [ACT_W-1:0] act, input logic [RANK_W-1:0] rank,
                                    input logic [POS_W-1:0] pos, input logic [AMT_W-1:0] amt);
        t_in it;
        it.action   = act;
        it.rank     = rank;
        it.position = pos;
        it.amount   = amt;
        return it;
    endfunction

    // Random item: unused fields carry noise, while the fields that matter
    // mostly land where the tree does real work (ranks within the total,
    // positions in use, small changes biased upward so removes do not empty it).
    function automatic t_in random_item();
        t_in it;
        int  r;
        int  amt;
        it.rank     = RANK_W'($urandom());
        it.position = POS_W'($urandom());
        it.amount   = AMT_W'($urandom());
        r = $urandom_range(0, 99);
        if (r < 40)
            it.action = ACT_SELECT;
        else if (r < 65)
            it.action = ACT_ADD;
        else if (r < 95)
            it.action = ACT_REMOVE;
        else
            it.action = ACT_SPARE;

        r = $urandom_range(0, 99);
        if (r < 80 && model_total > 0)
            it.rank = RANK_W'($urandom_range(1, model_total));
        else if (r < 88)
            it.rank = '0;
        else if (r < 92)
            it.rank = RANK_TOP;

        r = $urandom_range(0, 99);
        if (r < 85)
            it.position = POS_W'($urandom_range(1, span_now));
        else if (r < 90)
            it.position = '0;
        else
            it.position = POS_W'($urandom_range(span_now + 1, POS_TOP));

        r = $urandom_range(0, 99);
        if (r < 70) begin
            amt = $urandom_range(0, 8);
            it.amount = AMT_W'(amt - 2);
        end else if (r < 75) begin
            it.amount = 16'sh7FFF;
        end else if (r < 80) begin
            it.amount = 16'sh8000;
        end
        return it;
    endfunction

    initial begin
        int ph;
        int n;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        items_sent  = 0;
        burst_left  = 0;
        span_now    = RESET_USED_SIZE;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset size, where every count is one.
        send_item(mk_item(ACT_SELECT, 0, 5, 0));           // rank zero picks position 1
        send_item(mk_item(ACT_SELECT, 1, 0, 16'hFFFF));
        send_item(mk_item(ACT_SELECT, 1024, 0, 0));        // exactly the total
        send_item(mk_item(ACT_SELECT, 1025, 0, 0));        // just above the total
        send_item(mk_item(ACT_SELECT, RANK_TOP, POS_TOP, 16'h8000));
        send_item(mk_item(ACT_SPARE, 513, 7, 3));          // unused code acts as select
        send_item(mk_item(ACT_ADD, 0, 1, 16'h7FFF));
        send_item(mk_item(ACT_ADD, 0, 1, 16'h7FFF));
        send_item(mk_item(ACT_ADD, 0, 1, 16'h7FFF));       // saturates high
        send_item(mk_item(ACT_ADD, 0, 2, 16'h8000));       // saturates at zero
        send_item(mk_item(ACT_ADD, 0, 0, 5));              // position zero is ignored
        send_item(mk_item(ACT_ADD, 0, 1024, 16'hFFFF));    // last position down to zero
        send_item(mk_item(ACT_ADD, 0, 1025, 3));           // one past the end
        send_item(mk_item(ACT_ADD, RANK_TOP, POS_TOP, 16'hFFFF));
        send_item(mk_item(ACT_REMOVE, 1, 0, 0));
        send_item(mk_item(ACT_REMOVE, 0, 0, 0));           // out of range still decrements
        send_item(mk_item(ACT_REMOVE, RANK_TOP, 0, 0));    // lands on an empty count
        send_item(mk_item(ACT_SELECT, 65534, 0, 0));       // walks past the empty count
        send_item(mk_item(ACT_REMOVE, 65534, 0, 0));
        send_item(mk_item(ACT_SELECT, 200, POS_TOP, 16'h8000));
        send_item(mk_item(ACT_ADD, 0, 512, 0));

        // Random phases over a spread of sizes: the smallest, zero and
        // oversized writes that clamp, and shrinking then growing again so
        // counts beyond the size are held and come back.
        phase_spans = '{1, 2, 0, 7, 2047, 1025, 64, 3, 0, 16, 1000, 1024};
        phase_spans[8] = $urandom_range(4, 300);
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            write_span(POS_W'(phase_spans[ph]));
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_item(random_item());
                // pause the stream until the block has emptied, once for sure
                if ((ph == 0 && n == ITEMS_PER_PHASE / 2) || $urandom_range(0, 199) == 0)
                    drain();
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && results_seen == items_sent)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
